[design/bpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

    typedef struct packed {
        logic [15:0] raw_temp;
        logic [18:0] raw_pressure;
    } t_in;

    typedef struct packed {
        logic signed [31:0] temp_centideg;
        logic signed [31:0] pressure_pa;
        logic               divide_fault;
    } t_out;

    // queue entry: the raw readings of one command
    typedef struct packed {
        logic [15:0] ut;
        logic [18:0] up;
    } t_job;

    // register indexes
    localparam logic [2:0] REG_AC1_AC2 = 3'd0;
    localparam logic [2:0] REG_AC3_AC4 = 3'd1;
    localparam logic [2:0] REG_AC5_AC6 = 3'd2;
    localparam logic [2:0] REG_B1_B2   = 3'd3;
    localparam logic [2:0] REG_MC_MD   = 3'd4;
    localparam logic [2:0] REG_OSS     = 3'd5;

    localparam logic [31:0] C_4000  = 32'd4000;
    localparam logic [31:0] C_50000 = 32'd50000;
    localparam logic [31:0] C_32768 = 32'd32768;
    localparam logic [31:0] C_MSB   = 32'h8000_0000;
    localparam logic [31:0] C_3038  = 32'd3038;
    localparam logic [31:0] C_M7357 = 32'hFFFF_E343;
    localparam logic [31:0] C_3791  = 32'd3791;

    // back end sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_X1A, S_X1B, S_DEN, S_DIV1, S_B5, S_TEMP,
        S_SQ, S_SQ2, S_P1, S_P2, S_P3, S_P4, S_B3,
        S_B4A, S_B4B, S_B7, S_DIV2, S_PF, S_PX1, S_PX2, S_PX3, S_DONE
    } t_state;

endpackage
`default_nettype wire

[design/bpc_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// unsigned 32-bit restoring divider, one quotient bit per cycle
module bpc_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire logic [31:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_quo
);
    logic [31:0] r_q, n_q;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_run, n_run;
    logic        r_done, n_done;
    logic [32:0] w_try;

    // one shift-subtract step
    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        w_try  = {r_rem, r_q[31]} - {1'b0, r_den};
        if (i_go) begin
            n_q   = i_num;
            n_rem = '0;
            n_cnt = 6'd32;
            n_run = 1'b1;
        end else if (r_run) begin
            if (!w_try[32]) begin
                n_rem = w_try[31:0];
                n_q   = {r_q[30:0], 1'b1};
            end else begin
                n_rem = {r_rem[30:0], r_q[31]};
                n_q   = {r_q[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_go) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule
`default_nettype wire

[design/bpc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// front end: takes commands into a two-entry queue
module bpc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire bpc_pkg::t_in  i_data,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_avail,
    output bpc_pkg::t_job      o_job
);
    bpc_pkg::t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) begin
            r_mem[r_wp].ut <= i_data.raw_temp;
            r_mem[r_wp].up <= i_data.raw_pressure;
        end
    end

    assign o_full  = r_cnt[1];
    assign o_avail = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];
endmodule
`default_nettype wire

[design/bpc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// back end: sequencer over one multiplier and a shared divider
module bpc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_avail,
    input  wire bpc_pkg::t_job i_job,
    output logic               o_pop,
    input  wire logic [31:0]   i_c0,
    input  wire logic [31:0]   i_c1,
    input  wire logic [31:0]   i_c2,
    input  wire logic [31:0]   i_c3,
    input  wire logic [31:0]   i_c4,
    input  wire logic [1:0]    i_oss,
    output logic               o_strobe,
    output bpc_pkg::t_out      o_res
);
    bpc_pkg::t_state r_st, n_st;
    logic [31:0] r_x1, r_a, r_b, r_b5, r_b6, r_sq, r_t, r_b3, r_p, r_x2, r_b7;
    logic [31:0] n_x1, n_a, n_b, n_b5, n_b6, n_sq, n_t, n_b3, n_p, n_x2, n_b7;
    logic [15:0] r_ut;
    logic [18:0] r_up;
    logic        r_neg, n_neg, r_big, n_big;
    logic        n_strobe;
    bpc_pkg::t_out n_res;
    logic        w_go;
    logic [31:0] w_num, w_den, w_quo, w_prod;
    logic        w_done;

    // coefficient unpack
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = {{16{i_c0[31]}}, i_c0[31:16]};
    assign ac2 = {{16{i_c0[15]}}, i_c0[15:0]};
    assign ac3 = {{16{i_c1[31]}}, i_c1[31:16]};
    assign ac4 = {16'd0, i_c1[15:0]};
    assign ac5 = {16'd0, i_c2[31:16]};
    assign ac6 = {16'd0, i_c2[15:0]};
    assign b1  = {{16{i_c3[31]}}, i_c3[31:16]};
    assign b2  = {{16{i_c3[15]}}, i_c3[15:0]};
    assign mc  = {{16{i_c4[31]}}, i_c4[31:16]};
    assign md  = {{16{i_c4[15]}}, i_c4[15:0]};

    // shared 32x32 multiplier, low word, on registered operands
    assign w_prod = r_a * r_b;

    bpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_done),
        .o_quo   (w_quo)
    );

    function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
        asr = 32'($signed(x) >>> n);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= bpc_pkg::S_IDLE;
            o_strobe <= 1'b0;
        end else begin
            r_st     <= n_st;
            o_strobe <= n_strobe;
        end
        r_x1 <= n_x1; r_a <= n_a; r_b <= n_b; r_b5 <= n_b5; r_b6 <= n_b6;
        r_sq <= n_sq; r_t <= n_t; r_b3 <= n_b3; r_p <= n_p; r_x2 <= n_x2;
        r_b7 <= n_b7; r_neg <= n_neg; r_big <= n_big;
        o_res <= n_res;
        if (o_pop) begin
            r_ut <= i_job.ut;
            r_up <= i_job.up;
        end
    end

    // next state and datapath steps
    always_comb begin
        logic [31:0] num, den, sum;
        n_st = r_st;
        n_x1 = r_x1; n_a = r_a; n_b = r_b; n_b5 = r_b5; n_b6 = r_b6;
        n_sq = r_sq; n_t = r_t; n_b3 = r_b3; n_p = r_p; n_x2 = r_x2;
        n_b7 = r_b7; n_neg = r_neg; n_big = r_big;
        n_strobe = 1'b0;
        n_res = o_res;
        o_pop = 1'b0;
        w_go  = 1'b0;
        w_num = '0;
        w_den = '0;
        num = '0; den = '0; sum = '0;
        case (r_st)
            bpc_pkg::S_IDLE: begin
                if (i_avail) begin
                    o_pop = 1'b1;
                    n_st  = bpc_pkg::S_X1A;
                end
            end
            bpc_pkg::S_X1A: begin
                n_a  = {16'd0, r_ut} - ac6;
                n_b  = ac5;
                n_st = bpc_pkg::S_X1B;
            end
            bpc_pkg::S_X1B: begin
                n_x1 = asr(w_prod, 5'd15);
                n_st = bpc_pkg::S_DEN;
            end
            bpc_pkg::S_DEN: begin
                den = r_x1 + md;
                num = mc << 11;
                if (den == 32'd0) begin
                    n_res    = '{32'sd0, 32'sd0, 1'b1};
                    n_strobe = 1'b1;
                    n_st     = bpc_pkg::S_IDLE;
                end else begin
                    w_go  = 1'b1;
                    w_num = num[31] ? 32'd0 - num : num;
                    w_den = den[31] ? 32'd0 - den : den;
                    n_neg = num[31] ^ den[31];
                    n_st  = bpc_pkg::S_DIV1;
                end
            end
            bpc_pkg::S_DIV1: begin
                if (w_done) begin
                    n_b5 = r_x1 + (r_neg ? 32'd0 - w_quo : w_quo);
                    n_st = bpc_pkg::S_B5;
                end
            end
            bpc_pkg::S_B5: begin
                n_a  = r_b5;
                n_b  = 32'd10;
                n_b6 = r_b5 - bpc_pkg::C_4000;
                n_st = bpc_pkg::S_TEMP;
            end
            bpc_pkg::S_TEMP: begin
                n_t  = asr(w_prod + 32'd8, 5'd4);
                n_a  = r_b6;
                n_b  = r_b6;
                n_st = bpc_pkg::S_SQ;
            end
            bpc_pkg::S_SQ: begin
                n_sq = asr(w_prod, 5'd12);
                n_st = bpc_pkg::S_SQ2;
            end
            bpc_pkg::S_SQ2: begin
                n_a  = r_sq;
                n_b  = b2;
                n_st = bpc_pkg::S_P1;
            end
            bpc_pkg::S_P1: begin
                n_x1 = asr(w_prod, 5'd11);
                n_a  = ac2;
                n_b  = r_b6;
                n_st = bpc_pkg::S_P2;
            end
            bpc_pkg::S_P2: begin
                sum  = (ac1 << 2) + r_x1 + asr(w_prod, 5'd11);
                n_b3 = asr((sum << i_oss) + 32'd2, 5'd2);
                n_a  = ac3;
                n_b  = r_b6;
                n_st = bpc_pkg::S_P3;
            end
            bpc_pkg::S_P3: begin
                n_x1 = asr(w_prod, 5'd13);
                n_a  = b1;
                n_b  = r_sq;
                n_st = bpc_pkg::S_P4;
            end
            bpc_pkg::S_P4: begin
                sum  = asr(r_x1 + asr(w_prod, 5'd16) + 32'd2, 5'd2);
                n_a  = ac4;
                n_b  = sum + bpc_pkg::C_32768;
                n_st = bpc_pkg::S_B3;
            end
            bpc_pkg::S_B3: begin
                n_x2 = w_prod >> 15;
                n_a  = {13'd0, r_up} - r_b3;
                n_b  = bpc_pkg::C_50000 >> i_oss;
                n_st = bpc_pkg::S_B4A;
            end
            bpc_pkg::S_B4A: begin
                n_b7 = w_prod;
                n_st = bpc_pkg::S_B4B;
            end
            bpc_pkg::S_B4B: begin
                if (r_x2 == 32'd0) begin
                    n_res    = '{32'sd0, 32'sd0, 1'b1};
                    n_strobe = 1'b1;
                    n_st     = bpc_pkg::S_IDLE;
                end else begin
                    n_big = r_b7 >= bpc_pkg::C_MSB;
                    w_go  = 1'b1;
                    w_num = (r_b7 >= bpc_pkg::C_MSB) ? r_b7 : (r_b7 << 1);
                    w_den = r_x2;
                    n_st  = bpc_pkg::S_DIV2;
                end
            end
            bpc_pkg::S_DIV2: begin
                if (w_done) begin
                    n_p  = r_big ? (w_quo << 1) : w_quo;
                    n_st = bpc_pkg::S_B7;
                end
            end
            bpc_pkg::S_B7: begin
                n_a  = asr(r_p, 5'd8);
                n_b  = asr(r_p, 5'd8);
                n_st = bpc_pkg::S_PF;
            end
            bpc_pkg::S_PF: begin
                n_a  = w_prod;
                n_b  = bpc_pkg::C_3038;
                n_st = bpc_pkg::S_PX1;
            end
            bpc_pkg::S_PX1: begin
                n_x1 = asr(w_prod, 5'd16);
                n_a  = r_p;
                n_b  = bpc_pkg::C_M7357;
                n_st = bpc_pkg::S_PX2;
            end
            bpc_pkg::S_PX2: begin
                n_x2 = asr(w_prod, 5'd16);
                n_st = bpc_pkg::S_PX3;
            end
            bpc_pkg::S_PX3: begin
                n_p  = r_p + asr(r_x1 + r_x2 + bpc_pkg::C_3791, 5'd4);
                n_st = bpc_pkg::S_DONE;
            end
            bpc_pkg::S_DONE: begin
                n_res    = '{$signed(r_t), $signed(r_p), 1'b0};
                n_strobe = 1'b1;
                n_st     = bpc_pkg::S_IDLE;
            end
            default: n_st = bpc_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[design/baro_pressure_temp_compensation.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel  | handshake                 | payload
// command  | i_start / o_busy          | i_in  (bpc_pkg::t_in)
// result   | o_strobe (one cycle)      | o_out (bpc_pkg::t_out)
// config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
// per item: two divisions (fewer on a zero divisor), twelve multiplier steps
// and the other sequencer steps in the back end; a two-entry queue takes
// commands meanwhile. o_busy is high while the queue is full; one strobe each.
// synchronous active-low reset clears the queue, sequencer and coefficients
// (oversampling resets to 3). the receiver cannot stall.
module baro_pressure_temp_compensation (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output logic               o_busy,
    input  wire bpc_pkg::t_in  i_in,
    output logic               o_strobe,
    output bpc_pkg::t_out      o_out,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data
);
    logic [31:0] r_c0, r_c1, r_c2, r_c3, r_c4;
    logic [1:0]  r_oss;
    logic        w_full, w_avail, w_pop;
    bpc_pkg::t_job w_job;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = w_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= '0; r_c1 <= '0; r_c2 <= '0; r_c3 <= '0; r_c4 <= '0;
            r_oss <= 2'd3;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bpc_pkg::REG_AC1_AC2: r_c0 <= i_cfg_data;
                bpc_pkg::REG_AC3_AC4: r_c1 <= i_cfg_data;
                bpc_pkg::REG_AC5_AC6: r_c2 <= i_cfg_data;
                bpc_pkg::REG_B1_B2:   r_c3 <= i_cfg_data;
                bpc_pkg::REG_MC_MD:   r_c4 <= i_cfg_data;
                bpc_pkg::REG_OSS:     r_oss <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    bpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_start && !w_full),
        .i_data  (i_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_avail (w_avail),
        .o_job   (w_job)
    );

    bpc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (w_avail),
        .i_job    (w_job),
        .o_pop    (w_pop),
        .i_c0     (r_c0),
        .i_c1     (r_c1),
        .i_c2     (r_c2),
        .i_c3     (r_c3),
        .i_c4     (r_c4),
        .i_oss    (r_oss),
        .o_strobe (o_strobe),
        .o_res    (o_out)
    );
endmodule
`default_nettype wire
